FILE: src/varint_kv_record_deframer_assert.svh
// Assertion macros shared by the deframer checkers.
`ifndef VARINT_KV_RECORD_DEFRAMER_ASSERT_SVH
`define VARINT_KV_RECORD_DEFRAMER_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define VKD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define VKD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/vkd_pkg.sv
// Types, constants and helpers shared by the key/value deframer modules.
package vkd_pkg;

	localparam int LEN_BITS_DEF   = 32;
	localparam int INDEX_BITS_DEF = 32;

	// Result queue depth, a power of two of at least two.
	localparam int FIFO_DEPTH = 4;

	localparam int ENTRY_W = 32;
	localparam int TDATA_W = 40;
	localparam int TUSER_W = 4;

	typedef enum logic [2:0] {
		KIND_KEY   = 3'd0,
		KIND_VAL   = 3'd1,
		KIND_EKEY  = 3'd2,
		KIND_EVAL  = 3'd3,
		KIND_TRUNC = 3'd4,
		KIND_OVER  = 3'd5,
		KIND_DONE  = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [7:0]          out_byte;
		logic                field_end;
		logic [ENTRY_W-1:0]  entry_number;
		logic                last_of_run;
	} res_t;

	// Results of one input byte: count, then up to two results in order.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r1;
		res_t       r0;
	} push_t;

	function automatic res_t make_res(kind_t k, logic [7:0] b, logic fe,
			logic [ENTRY_W-1:0] e);
		res_t r;
		r.kind         = k;
		r.out_byte     = b;
		r.field_end    = fe;
		r.entry_number = e;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

FILE: src/vkd_parser.sv
// Byte-level parser: varint decoding, phase sequencing and result generation.
module vkd_parser #(
	parameter int LEN_BITS   = vkd_pkg::LEN_BITS_DEF,
	parameter int INDEX_BITS = vkd_pkg::INDEX_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      in_byte,
	input  logic            in_eob,
	output vkd_pkg::push_t  push
);

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_KLEN,
		PH_KEY,
		PH_VLEN,
		PH_VAL,
		PH_DONE,
		PH_HALT
	} phase_t;

	// Tenth varint byte carries only bit 63.
	localparam logic [3:0] VARINT_LAST = 4'd9;

	phase_t                phase_q, phase_d;
	logic [63:0]           acc_q, acc_d;
	logic [3:0]            vidx_q, vidx_d;
	logic [63:0]           entries_q, entries_d;
	logic [LEN_BITS-1:0]   bytes_q, bytes_d;
	logic [INDEX_BITS-1:0] ctr_q, ctr_d;

	logic [63:0] slice;
	logic [63:0] vval;
	logic        v_over, v_more, v_done, v_zero, v_big;
	logic        do_finish;
	logic [1:0]  n;
	vkd_pkg::res_t res [2];

	always_comb begin
		slice = '0;
		for (int k = 0; k < 9; k++) begin
			if (vidx_q == 4'(k)) slice[7*k +: 7] = in_byte[6:0];
		end
		if (vidx_q == VARINT_LAST) slice[63] = in_byte[0];
	end

	assign vval   = acc_q | slice;
	assign v_over = (vidx_q == VARINT_LAST) && (in_byte[7:1] != 7'd0);
	assign v_more = (vidx_q != VARINT_LAST) && in_byte[7];
	assign v_done = !v_over && !v_more;
	assign v_zero = (vval == 64'd0);
	assign v_big  = |vval[63:LEN_BITS];

	always_comb begin
		phase_d   = phase_q;
		acc_d     = acc_q;
		vidx_d    = vidx_q;
		entries_d = entries_q;
		bytes_d   = bytes_q;
		ctr_d     = ctr_q;
		do_finish = 1'b0;
		n         = 2'd0;
		res[0]    = '0;
		res[1]    = '0;
		if (fire) begin
			unique case (phase_q)
				PH_COUNT: begin
					if (v_over) begin
						res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_OVER, 8'd0, 1'b0,
							32'(ctr_q));
						n = n + 2'd1;
						phase_d = PH_HALT;
					end else if (v_more) begin
						acc_d  = vval;
						vidx_d = vidx_q + 4'd1;
					end else begin
						acc_d     = '0;
						vidx_d    = '0;
						entries_d = vval;
						if (v_zero) begin
							res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_DONE, 8'd0, 1'b0,
								32'(ctr_q));
							n = n + 2'd1;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_KLEN;
						end
					end
				end
				PH_KLEN, PH_VLEN: begin
					if (v_over || (v_done && v_big)) begin
						res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_OVER, 8'd0, 1'b0,
							32'(ctr_q));
						n = n + 2'd1;
						phase_d = PH_HALT;
					end else if (v_more) begin
						acc_d  = vval;
						vidx_d = vidx_q + 4'd1;
					end else begin
						acc_d   = '0;
						vidx_d  = '0;
						bytes_d = vval[LEN_BITS-1:0];
						if (phase_q == PH_KLEN) begin
							if (v_zero) begin
								res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_EKEY, 8'd0,
									1'b1, 32'(ctr_q));
								n = n + 2'd1;
								phase_d = PH_VLEN;
							end else begin
								phase_d = PH_KEY;
							end
						end else begin
							if (v_zero) begin
								res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_EVAL, 8'd0,
									1'b1, 32'(ctr_q));
								n = n + 2'd1;
								do_finish = 1'b1;
							end else begin
								phase_d = PH_VAL;
							end
						end
					end
				end
				PH_KEY: begin
					res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_KEY, in_byte,
						bytes_q == LEN_BITS'(1), 32'(ctr_q));
					n = n + 2'd1;
					bytes_d = bytes_q - LEN_BITS'(1);
					if (bytes_q == LEN_BITS'(1)) phase_d = PH_VLEN;
				end
				PH_VAL: begin
					res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_VAL, in_byte,
						bytes_q == LEN_BITS'(1), 32'(ctr_q));
					n = n + 2'd1;
					bytes_d = bytes_q - LEN_BITS'(1);
					if (bytes_q == LEN_BITS'(1)) do_finish = 1'b1;
				end
				default: begin
				end
			endcase

			// Close the entry; the last one reports the entry total.
			if (do_finish) begin
				ctr_d     = ctr_q + INDEX_BITS'(1);
				entries_d = entries_q - 64'd1;
				if (entries_q == 64'd1) begin
					res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_DONE, 8'd0, 1'b0,
						32'(ctr_d));
					n = n + 2'd1;
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_KLEN;
				end
			end

			if (in_eob) begin
				if (phase_d != PH_DONE && phase_d != PH_HALT) begin
					res[n[0]] = vkd_pkg::make_res(vkd_pkg::KIND_TRUNC, 8'd0, 1'b0,
						32'(ctr_d));
					n = n + 2'd1;
				end
				phase_d   = PH_COUNT;
				acc_d     = '0;
				vidx_d    = '0;
				entries_d = '0;
				bytes_d   = '0;
				ctr_d     = '0;
			end

			if (n == 2'd2) begin
				res[1].last_of_run = 1'b1;
			end else if (n == 2'd1) begin
				res[0].last_of_run = 1'b1;
			end
		end
	end

	assign push.cnt = n;
	assign push.r0  = res[0];
	assign push.r1  = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			acc_q     <= '0;
			vidx_q    <= '0;
			entries_q <= '0;
			bytes_q   <= '0;
			ctr_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			acc_q     <= acc_d;
			vidx_q    <= vidx_d;
			entries_q <= entries_d;
			bytes_q   <= bytes_d;
			ctr_q     <= ctr_d;
		end
	end

endmodule

FILE: src/vkd_res_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while pop is high.
module vkd_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  vkd_pkg::push_t push,
	input  logic           pop,
	output logic           room,
	output logic           head_valid,
	output vkd_pkg::res_t  head
);

	localparam int DEPTH = vkd_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	vkd_pkg::res_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop     = pop && head_valid;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	// Leave space for the two results one byte can cause.
	assign room       = (count_q <= CNT_W'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.cnt);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(do_pop);
		end
	end

endmodule

FILE: src/varint_kv_record_deframer.sv
// Top level of the LEB128 length-prefixed key/value record deframer.
// Takes one buffer byte per cycle on the slave side and passes out key and value
// bytes, empty-field markers, done, truncated and overlong results on the master
// side, tagged with the entry index. A byte goes through an input register and the
// parser into a four-entry result queue, and its first result is valid on the
// master side once it is written into the queue. A byte is accepted each cycle
// while the queue has room for two results, so the input runs at one byte per
// cycle until the output side, which delivers one result per cycle while
// m_axis_tready is high, falls behind. No memory clearing after reset.
module varint_kv_record_deframer #(
	parameter int LEN_BITS   = vkd_pkg::LEN_BITS_DEF,
	parameter int INDEX_BITS = vkd_pkg::INDEX_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // data_byte[7:0]
	input  logic                        s_axis_tlast,  // end_of_buffer
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [vkd_pkg::TDATA_W-1:0] m_axis_tdata,  // out_byte[7:0], entry_number[39:8]
	output logic [vkd_pkg::TUSER_W-1:0] m_axis_tuser,  // kind[2:0], field_end[3]
	output logic                        m_axis_tlast   // last_of_run
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           eob_s1;
	logic           take, fire, room;
	vkd_pkg::push_t push;
	vkd_pkg::res_t  head;

	assign fire          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || fire;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_axis_tdata;
			eob_s1  <= s_axis_tlast;
		end
	end

	vkd_parser #(
		.LEN_BITS   (LEN_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_byte (byte_s1),
		.in_eob  (eob_s1),
		.push    (push)
	);

	vkd_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (m_axis_tready),
		.room       (room),
		.head_valid (m_axis_tvalid),
		.head       (head)
	);

	assign m_axis_tdata = {head.entry_number, head.out_byte};
	assign m_axis_tuser = {head.field_end, head.kind};
	assign m_axis_tlast = head.last_of_run;

endmodule

FILE: src/vkd_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "varint_kv_record_deframer_assert.svh"

module vkd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [vkd_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic [vkd_pkg::TUSER_W-1:0] m_axis_tuser,
	input logic                        m_axis_tlast
);

	`VKD_ASSERT(a_marker_no_byte, clk, arst_n, m_axis_tvalid && m_axis_tuser[2:0] != vkd_pkg::KIND_KEY && m_axis_tuser[2:0] != vkd_pkg::KIND_VAL |-> m_axis_tdata[7:0] == 8'd0, "marker item carries a data byte")
	`VKD_ASSERT(a_empty_ends_field, clk, arst_n, m_axis_tvalid && (m_axis_tuser[2:0] == vkd_pkg::KIND_EKEY || m_axis_tuser[2:0] == vkd_pkg::KIND_EVAL) |-> m_axis_tuser[3], "empty marker without field end")
	`VKD_ASSERT(a_final_is_last, clk, arst_n, m_axis_tvalid && (m_axis_tuser[2:0] == vkd_pkg::KIND_TRUNC || m_axis_tuser[2:0] == vkd_pkg::KIND_OVER || m_axis_tuser[2:0] == vkd_pkg::KIND_DONE) |-> m_axis_tlast, "closing item not last of its run")
	`VKD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled output item changed")

endmodule

bind varint_kv_record_deframer vkd_checker u_vkd_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the LEB128 key/value record deframer.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_BYTES = 260;
	localparam logic [63:0] LEN_MAX  = (64'd1 << vkd_pkg::LEN_BITS_DEF) - 64'd1;
	localparam logic [63:0] IDX_MASK = (vkd_pkg::INDEX_BITS_DEF >= 64) ? '1 :
		(64'd1 << vkd_pkg::INDEX_BITS_DEF) - 64'd1;

	typedef enum logic [2:0] {
		ST_COUNT, ST_KEY_LEN, ST_KEY, ST_VAL_LEN, ST_VAL, ST_FINISHED, ST_HALTED
	} parse_state_t;

	typedef enum logic [1:0] {VI_MORE, VI_DONE, VI_OVERLONG} varint_status_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata = 8'd0;
	logic                        s_axis_tlast = 1'b0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [vkd_pkg::TDATA_W-1:0] m_axis_tdata;
	logic [vkd_pkg::TUSER_W-1:0] m_axis_tuser;
	logic                        m_axis_tlast;

	varint_kv_record_deframer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	class record_scoreboard_t;
		vkd_pkg::res_t pending_results[$];
		vkd_pkg::res_t step_results[$];
		int            errors;
		int            bytes_in;
		int            buffers;
		int            checked;
		int            kind_seen[7];
		parse_state_t  state;
		logic [63:0]   accum;
		logic [6:0]    shift;
		logic [63:0]   entries_left;
		logic [63:0]   bytes_left;
		logic [63:0]   entry_idx;

		function new();
			errors = 0;
			bytes_in = 0;
			buffers = 0;
			checked = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			restart();
		endfunction

		function void restart();
			state = ST_COUNT;
			accum = '0;
			shift = '0;
			entries_left = '0;
			bytes_left = '0;
			entry_idx = '0;
		endfunction

		function void emit(vkd_pkg::kind_t k, logic [7:0] b, logic fe);
			vkd_pkg::res_t r;
			if (step_results.size() >= 2)
				return;
			r.kind = k;
			r.out_byte = b;
			r.field_end = fe;
			r.entry_number = entry_idx[vkd_pkg::ENTRY_W-1:0];
			r.last_of_run = 1'b0;
			step_results = {step_results, r};
		endfunction

		function varint_status_t feed_varint(logic [7:0] b, output logic [63:0] v);
			v = '0;
			if (shift >= 7'd63) begin
				if (b[7:1] != 7'd0)
					return VI_OVERLONG;
				accum[63] = accum[63] | b[0];
			end else begin
				accum = accum | ({57'd0, b[6:0]} << shift);
			end
			if (b[7]) begin
				shift = shift + 7'd7;
				return VI_MORE;
			end
			v = accum;
			accum = '0;
			shift = '0;
			return VI_DONE;
		endfunction

		function void close_entry();
			entry_idx = (entry_idx + 64'd1) & IDX_MASK;
			entries_left = entries_left - 64'd1;
			if (entries_left == 64'd0) begin
				emit(vkd_pkg::KIND_DONE, 8'd0, 1'b0);
				state = ST_FINISHED;
			end else begin
				state = ST_KEY_LEN;
			end
		endfunction

		// Advance the parse by one accepted byte and queue the results it causes.
		function void note_input(logic [7:0] b, logic eob);
			varint_status_t st;
			logic [63:0] v;
			step_results.delete();
			bytes_in++;
			case (state)
				ST_COUNT: begin
					st = feed_varint(b, v);
					if (st == VI_OVERLONG) begin
						emit(vkd_pkg::KIND_OVER, 8'd0, 1'b0);
						state = ST_HALTED;
					end else if (st == VI_DONE) begin
						entries_left = v;
						if (v == 64'd0) begin
							emit(vkd_pkg::KIND_DONE, 8'd0, 1'b0);
							state = ST_FINISHED;
						end else begin
							state = ST_KEY_LEN;
						end
					end
				end
				ST_KEY_LEN, ST_VAL_LEN: begin
					st = feed_varint(b, v);
					if (st == VI_OVERLONG || (st == VI_DONE && v > LEN_MAX)) begin
						emit(vkd_pkg::KIND_OVER, 8'd0, 1'b0);
						state = ST_HALTED;
					end else if (st == VI_DONE) begin
						if (state == ST_KEY_LEN) begin
							if (v == 64'd0) begin
								emit(vkd_pkg::KIND_EKEY, 8'd0, 1'b1);
								state = ST_VAL_LEN;
							end else begin
								bytes_left = v;
								state = ST_KEY;
							end
						end else begin
							if (v == 64'd0) begin
								emit(vkd_pkg::KIND_EVAL, 8'd0, 1'b1);
								close_entry();
							end else begin
								bytes_left = v;
								state = ST_VAL;
							end
						end
					end
				end
				ST_KEY: begin
					emit(vkd_pkg::KIND_KEY, b, bytes_left == 64'd1);
					bytes_left = bytes_left - 64'd1;
					if (bytes_left == 64'd0)
						state = ST_VAL_LEN;
				end
				ST_VAL: begin
					emit(vkd_pkg::KIND_VAL, b, bytes_left == 64'd1);
					bytes_left = bytes_left - 64'd1;
					if (bytes_left == 64'd0)
						close_entry();
				end
				default: ;
			endcase
			if (eob) begin
				if (state != ST_FINISHED && state != ST_HALTED)
					emit(vkd_pkg::KIND_TRUNC, 8'd0, 1'b0);
				buffers++;
				restart();
			end
			if (step_results.size() > 0)
				step_results[step_results.size() - 1].last_of_run = 1'b1;
			pending_results = {pending_results, step_results};
		endfunction

		function void check_result(vkd_pkg::res_t got);
			vkd_pkg::res_t want;
			checked++;
			if (got.kind <= vkd_pkg::KIND_DONE)
				kind_seen[got.kind]++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none", $time);
				$display("%0t:   actual kind=%0d byte=%02h end=%b entry=%0d last=%b",
					$time, got.kind, got.out_byte, got.field_end, got.entry_number,
					got.last_of_run);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
					got.field_end !== want.field_end ||
					got.entry_number !== want.entry_number ||
					got.last_of_run !== want.last_of_run) begin
				errors++;
				$display("%0t: result mismatch: expected kind=%0d byte=%02h end=%b entry=%0d last=%b",
					$time, want.kind, want.out_byte, want.field_end, want.entry_number,
					want.last_of_run);
				$display("%0t:                  actual   kind=%0d byte=%02h end=%b entry=%0d last=%b",
					$time, got.kind, got.out_byte, got.field_end, got.entry_number,
					got.last_of_run);
			end
		endfunction
	endclass

	record_scoreboard_t sb;
	bit hold_req = 1'b0;
	bit quiet = 1'b0;
	int burst_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : monitor
		vkd_pkg::res_t got;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_input(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = vkd_pkg::kind_t'(m_axis_tuser[2:0]);
			got.field_end = m_axis_tuser[3];
			got.out_byte = m_axis_tdata[7:0];
			got.entry_number = m_axis_tdata[39:8];
			got.last_of_run = m_axis_tlast;
			sb.check_result(got);
		end
	end

	// Receiver: changing stall patterns, plus a long hold-off on request.
	initial begin : receiver
		int mode;
		int span;
		int tick;
		mode = 0;
		span = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(40, 200);
				end
				span--;
				tick++;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (tick % 4 == 0);
					default: m_axis_tready <= ($urandom_range(0, 6) != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("** varint_kv_record_deframer: FAILED **");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		int gap;
		if (burst_left == 0) begin
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eob;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_buffer(input logic [7:0] bytes_q[$]);
		foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	// Hold input until every expected result is out and the pipeline is empty.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
		q = {q, b};
	endfunction

	// Append v as LEB128, padded with pad extra zero groups.
	function automatic void add_varint(ref logic [7:0] q[$], input logic [63:0] v,
			input int pad);
		logic [63:0] rest;
		logic [6:0] grp;
		int extra;
		rest = v;
		extra = pad;
		while (1) begin
			grp = rest[6:0];
			rest = rest >> 7;
			if (rest != 64'd0 || extra > 0) begin
				append_byte(q, {1'b1, grp});
				if (rest == 64'd0)
					extra--;
			end else begin
				append_byte(q, {1'b0, grp});
				break;
			end
		end
	endfunction

	function automatic int pick_len(input int max_len);
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(1, max_len);
	endfunction

	function automatic int pick_pad();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
	endfunction

	function automatic void add_records(ref logic [7:0] q[$], input int n, input int max_len);
		int klen;
		int vlen;
		add_varint(q, 64'(n), pick_pad());
		repeat (n) begin
			klen = pick_len(max_len);
			add_varint(q, 64'(klen), pick_pad());
			repeat (klen) append_byte(q, 8'($urandom_range(0, 255)));
			vlen = pick_len(max_len);
			add_varint(q, 64'(vlen), pick_pad());
			repeat (vlen) append_byte(q, 8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin : stimulus
		logic [7:0] q[$];
		logic [63:0] big;
		int sel;
		int cut;
		int start_bytes;
		int last_pause;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero entries: done at once.
		q = '{8'h00};
		send_buffer(q);
		// Buffer ends inside the count varint.
		q = '{8'h85};
		send_buffer(q);
		// Empty key and empty value in one entry; two results on the last byte.
		q = '{8'h01, 8'h00, 8'h00};
		send_buffer(q);
		// Two entries with extreme bytes, then ignored trailing bytes.
		q = '{8'h02, 8'h02, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h01, 8'h7F, 8'h00, 8'hAA, 8'h55};
		send_buffer(q);
		// Padded varints, end of buffer on the byte that finishes the last entry.
		q = '{8'h81, 8'h80, 8'h00, 8'h80, 8'h00, 8'h03, 8'h11, 8'h22, 8'h33};
		send_buffer(q);
		// Buffer ends inside a key.
		q = '{8'h01, 8'h03, 8'h61, 8'h62};
		send_buffer(q);
		// Overlong count, then ignored bytes.
		q.delete();
		repeat (9) append_byte(q, 8'hFF);
		append_byte(q, 8'h02);
		append_byte(q, 8'h00);
		send_buffer(q);
		// Largest count uses all 64 bits; one empty entry, then an early end.
		q.delete();
		repeat (9) append_byte(q, 8'hFF);
		append_byte(q, 8'h01);
		append_byte(q, 8'h00);
		append_byte(q, 8'h00);
		append_byte(q, 8'h80);
		send_buffer(q);
		// Key length one above the largest allowed.
		q = '{8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
		send_buffer(q);
		// Largest key length, one key byte, then an early end.
		q = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h12};
		send_buffer(q);
		// Value length too large after an empty key.
		q = '{8'h01, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h33};
		send_buffer(q);
		// Key length varint still continuing at its tenth byte.
		q.delete();
		append_byte(q, 8'h01);
		repeat (10) append_byte(q, 8'h80);
		send_buffer(q);
		wait_for_results();

		// Long receiver hold-off while the sender keeps offering.
		hold_req = 1'b1;
		quiet = 1'b1;
		q.delete();
		add_varint(q, 64'd3, 0);
		repeat (3) begin
			add_varint(q, 64'd8, 0);
			repeat (8) append_byte(q, 8'($urandom_range(0, 255)));
			add_varint(q, 64'd8, 0);
			repeat (8) append_byte(q, 8'($urandom_range(0, 255)));
		end
		send_buffer(q);
		quiet = 1'b0;
		wait_for_results();

		start_bytes = sb.bytes_in;
		last_pause = sb.bytes_in;
		while (sb.bytes_in - start_bytes < RANDOM_BYTES) begin
			q.delete();
			quiet = ($urandom_range(0, 5) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 65) begin
				add_records(q, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
					($urandom_range(0, 9) == 0) ? 24 : 6);
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) append_byte(q, 8'($urandom_range(0, 255)));
			end else if (sel < 80) begin
				add_records(q, $urandom_range(1, 4), 6);
				if (q.size() > 1) begin
					cut = $urandom_range(0, q.size() - 2);
					q = q[0:cut];
				end
			end else if (sel < 88) begin
				repeat (9) append_byte(q, {1'b1, 7'($urandom_range(0, 127))});
				append_byte(q, 8'($urandom_range(2, 255)));
				repeat ($urandom_range(0, 2)) append_byte(q, 8'($urandom_range(0, 255)));
			end else if (sel < 94) begin
				add_varint(q, 64'($urandom_range(1, 3)), 0);
				if ($urandom_range(0, 1) == 1)
					append_byte(q, 8'h00);
				big = {$urandom, $urandom};
				big[32 + $urandom_range(0, 31)] = 1'b1;
				add_varint(q, big, 0);
				append_byte(q, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 12)) append_byte(q, 8'($urandom_range(0, 255)));
			end
			send_buffer(q);
			if (sb.bytes_in - last_pause >= 120) begin
				wait_for_results();
				last_pause = sb.bytes_in;
			end
		end
		wait_for_results();

		if (sb.pending_results.size() != 0) begin
			sb.errors += sb.pending_results.size();
			$display("%0t: %0d expected results never came", $time, sb.pending_results.size());
		end
		$display("Run covered %0d buffers, %0d bytes in, %0d results checked.",
			sb.buffers, sb.bytes_in, sb.checked);
		$display("By kind: key %0d, value %0d, empty key %0d, empty value %0d,",
			sb.kind_seen[vkd_pkg::KIND_KEY], sb.kind_seen[vkd_pkg::KIND_VAL],
			sb.kind_seen[vkd_pkg::KIND_EKEY], sb.kind_seen[vkd_pkg::KIND_EVAL]);
		$display("         truncated %0d, overlong %0d, done %0d.",
			sb.kind_seen[vkd_pkg::KIND_TRUNC], sb.kind_seen[vkd_pkg::KIND_OVER],
			sb.kind_seen[vkd_pkg::KIND_DONE]);
		if (sb.errors == 0)
			$display("** varint_kv_record_deframer: PASSED **");
		else
			$display("** varint_kv_record_deframer: FAILED **");
		$finish;
	end

endmodule
